// ----- rtl/usm_pkg.sv -----
// Shared types, constants and tables of the UV sphere mesh generator.
package usm_pkg;

  localparam int IDX_W            = 7;
  localparam int CFG_W            = 15;
  localparam int RAD_W            = 15;
  localparam int KIDX_W           = 15;
  localparam int TEX_W            = 17;
  localparam int PHASE_W          = 32;
  localparam int ANG_W            = 31;
  localparam int ZW               = 32;
  localparam int CORDIC_STEPS     = 28;
  localparam int RECIP_SHIFT      = 40;
  localparam int RECIP_W          = 40;
  localparam int RECORDS_PER_ITEM = 3;
  localparam int BACK_LAT         = CORDIC_STEPS + 6;

  localparam int MAX_STACKS_DEF  = 64;
  localparam int MAX_SECTORS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MIN_STACKS      = 2;
  localparam int MIN_SECTORS     = 3;

  localparam logic [IDX_W-1:0] RESET_STACKS  = 7'd18;
  localparam logic [IDX_W-1:0] RESET_SECTORS = 7'd36;
  localparam logic [RAD_W-1:0] RESET_RADIUS  = 15'd16384;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 31'sd163008219;

  // arctangent of 2^-k in turn units, 2^32 per turn
  localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163,
    32'sd81, 32'sd41, 32'sd20, 32'sd10, 32'sd5
  };

  typedef enum logic [1:0] {
    REG_STACK_COUNT   = 2'd0,
    REG_SECTOR_COUNT  = 2'd1,
    REG_SPHERE_RADIUS = 2'd2
  } reg_index_t;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } record_kind_t;

  typedef struct packed {
    logic [IDX_W-1:0] stack_index;
    logic [IDX_W-1:0] sector_index;
  } item_t;

  typedef struct packed {
    logic               record_kind;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic signed [15:0] third_value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [TEX_W-1:0]   tex_s;
    logic [TEX_W-1:0]   tex_t;
    logic               last_of_item;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] stack_count;
    logic [IDX_W-1:0] sector_count;
    logic [RAD_W-1:0] sphere_radius;
  } cfg_t;

  // per-item data that rides alongside the trig pipeline
  typedef struct packed {
    logic [TEX_W-1:0]  ts;
    logic [TEX_W-1:0]  tt;
    logic [KIDX_W-1:0] k1;
    logic [KIDX_W-1:0] k2;
    logic              tri_a;
    logic              tri_b;
  } side_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_st;
    logic [PHASE_W-1:0] phase_se;
    side_t              side;
  } job_t;

endpackage

// ----- rtl/usm_front.sv -----
// Front end: range check, phase and texture division by reciprocal, triangle indices.
module usm_front #(
  parameter int MAX_STACKS  = usm_pkg::MAX_STACKS_DEF,
  parameter int MAX_SECTORS = usm_pkg::MAX_SECTORS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  usm_pkg::cfg_t  cfg,
  input  logic           take,
  input  usm_pkg::item_t item,
  output logic           push,
  output usm_pkg::job_t  job,
  output logic [1:0]     inflight
);

  localparam int IW = usm_pkg::IDX_W;
  localparam int RW = usm_pkg::RECIP_W;

  function automatic logic [IW-1:0] clamp_count(input logic [IW-1:0] v, input int lo,
                                                input int hi);
    if (int'(v) < lo) return IW'(lo);
    if (int'(v) > hi) return IW'(hi);
    return v;
  endfunction

  // one compare-and-add repairs a reciprocal quotient that may be one short
  function automatic logic [32:0] div_fix(input logic [39:0] num, input logic [32:0] q_est,
                                          input logic [IW-1:0] d);
    logic [39:0] prod;
    logic [39:0] rem;
    prod = 40'(q_est) * 40'(d);
    rem  = num - prod;
    return (rem >= 40'(d)) ? q_est + 33'd1 : q_est;
  endfunction

  logic [RW-1:0] recip_tab [2**IW];

  for (genvar g = 0; g < 2**IW; g++) begin : g_recip
    localparam longint unsigned D = (g < 2) ? 2 : g;
    localparam logic [RW-1:0] RV = RW'((64'd1 << usm_pkg::RECIP_SHIFT) / D);
    assign recip_tab[g] = RV;
  end

  logic [IW-1:0] st_c, se_c;
  logic          in_range, cell_ok;

  assign st_c     = clamp_count(cfg.stack_count, usm_pkg::MIN_STACKS, MAX_STACKS);
  assign se_c     = clamp_count(cfg.sector_count, usm_pkg::MIN_SECTORS, MAX_SECTORS);
  assign in_range = (item.stack_index <= st_c) && (item.sector_index <= se_c);
  assign cell_ok  = (item.stack_index < st_c) && (item.sector_index < se_c);

  // stage 0
  logic          v0;
  logic [IW-1:0] i0, j0, st0, se0;
  logic [RW-1:0] rst0, rse0;
  logic          ta0, tb0;
  // stage 1
  logic          v1;
  logic [IW-1:0] i1, j1, st1, se1;
  logic [46:0]   pi1, pj1;
  logic [45:0]   pih1, pjh1;
  logic [14:0]   k1_1;
  logic          ta1, tb1;
  // stage 2
  logic          v2;
  logic [IW-1:0] i2, j2, st2, se2;
  logic [32:0]   qst2, qse2;
  logic [16:0]   ts2, tt2;
  logic [14:0]   k1_2, k2_2;
  logic          ta2, tb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= take && in_range;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    i0   <= item.stack_index;
    j0   <= item.sector_index;
    st0  <= st_c;
    se0  <= se_c;
    rst0 <= recip_tab[st_c];
    rse0 <= recip_tab[se_c];
    ta0  <= cell_ok && (item.stack_index != '0);
    tb0  <= cell_ok && (item.stack_index != st_c - IW'(1));

    i1   <= i0;
    j1   <= j0;
    st1  <= st0;
    se1  <= se0;
    pi1  <= 47'(i0) * 47'(rst0);
    pih1 <= 46'(st0[IW-1:1]) * 46'(rst0);
    pj1  <= 47'(j0) * 47'(rse0);
    pjh1 <= 46'(se0[IW-1:1]) * 46'(rse0);
    k1_1 <= 15'(i0) * (15'(se0) + 15'd1) + 15'(j0);
    ta1  <= ta0;
    tb1  <= tb0;

    i2   <= i1;
    j2   <= j1;
    st2  <= st1;
    se2  <= se1;
    qst2 <= 33'(pi1 >> 9);
    qse2 <= 33'(pj1 >> 8);
    ts2  <= 17'(((64'(pi1) << 16) + 64'(pih1)) >> usm_pkg::RECIP_SHIFT);
    tt2  <= 17'(((64'(pj1) << 16) + 64'(pjh1)) >> usm_pkg::RECIP_SHIFT);
    k1_2 <= k1_1;
    k2_2 <= k1_1 + 15'(se1) + 15'd1;
    ta2  <= ta1;
    tb2  <= tb1;
  end

  logic [32:0] q_st, q_se, q_ts, q_tt;

  always_comb begin
    q_st = div_fix(40'(i2) << 31, qst2, st2);
    q_se = div_fix(40'(j2) << 32, qse2, se2);
    q_ts = div_fix((40'(i2) << 16) + 40'(st2[IW-1:1]), 33'(ts2), st2);
    q_tt = div_fix((40'(j2) << 16) + 40'(se2[IW-1:1]), 33'(tt2), se2);
  end

  assign push           = v2;
  assign job.phase_st   = 32'h4000_0000 - q_st[31:0];
  assign job.phase_se   = q_se[31:0];
  assign job.side.ts    = q_ts[16:0];
  assign job.side.tt    = q_tt[16:0];
  assign job.side.k1    = k1_2;
  assign job.side.k2    = k2_2;
  assign job.side.tri_a = ta2;
  assign job.side.tri_b = tb2;
  assign inflight       = 2'(v0) + 2'(v1) + 2'(v2);

endmodule

// ----- rtl/usm_queue.sv -----
// Short job queue between front and back end.
module usm_queue #(
  parameter int DEPTH = usm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  usm_pkg::job_t              push_data,
  input  logic                       pop,
  output usm_pkg::job_t              head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  usm_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head = mem[rd_ptr];

endmodule

// ----- rtl/usm_cordic.sv -----
// Pipelined rotation CORDIC: phase in turns to cosine and sine in Q2.28.
module usm_cordic (
  input  logic                                clk,
  input  logic [usm_pkg::PHASE_W-1:0]         phase,
  output logic signed [usm_pkg::ANG_W-1:0]    cos_out,
  output logic signed [usm_pkg::ANG_W-1:0]    sin_out
);

  localparam int N  = usm_pkg::CORDIC_STEPS;
  localparam int AW = usm_pkg::ANG_W;
  localparam int ZW = usm_pkg::ZW;

  logic signed [AW-1:0] x_r [N+1];
  logic signed [AW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [1:0]           quad_r [N+1];
  logic [31:0]          p;

  // fold to a residual in [-1/8, 1/8) turn plus a quadrant
  assign p = phase + 32'h2000_0000;

  always_ff @(posedge clk) begin
    x_r[0]    <= usm_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= $signed({2'b00, p[29:0]}) - 32'sh2000_0000;
    quad_r[0] <= p[31:30];
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!z_r[k][ZW-1]) begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - usm_pkg::ATAN_TURN[k];
      end else begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + usm_pkg::ATAN_TURN[k];
      end
      quad_r[k+1] <= quad_r[k];
    end
  end

  always_ff @(posedge clk) begin
    case (quad_r[N])
      2'd0: begin
        cos_out <= x_r[N];
        sin_out <= y_r[N];
      end
      2'd1: begin
        cos_out <= -y_r[N];
        sin_out <= x_r[N];
      end
      2'd2: begin
        cos_out <= -x_r[N];
        sin_out <= -y_r[N];
      end
      default: begin
        cos_out <= y_r[N];
        sin_out <= -x_r[N];
      end
    endcase
  end

endmodule

// ----- rtl/usm_back.sv -----
// Back end: trig, products, rounding and the record serializer.
module usm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [usm_pkg::RAD_W-1:0]   radius,
  input  logic                        not_empty,
  input  usm_pkg::job_t               head,
  output logic                        pop,
  output logic                        done,
  output usm_pkg::result_t            result
);

  localparam int LAT = usm_pkg::BACK_LAT;
  localparam int AW  = usm_pkg::ANG_W;

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int k);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    if (v > lim) return 16'(lim);
    if (v < -lim) return 16'(-lim);
    return 16'(v);
  endfunction

  // issue spacing: a gap counter holds off the next pop after each job, which keeps the serializer clear
  logic [1:0] gap;

  assign pop = not_empty && (gap == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (pop) begin
      gap <= 2'(usm_pkg::RECORDS_PER_ITEM - 1);
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  logic signed [AW-1:0] c_st, s_st, c_se, s_se;

  usm_cordic u_cordic_st (.clk(clk), .phase(head.phase_st), .cos_out(c_st), .sin_out(s_st));
  usm_cordic u_cordic_se (.clk(clk), .phase(head.phase_se), .cos_out(c_se), .sin_out(s_se));

  logic               dl_v [LAT];
  usm_pkg::side_t     dl_s [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < LAT; n++) dl_v[n] <= 1'b0;
    end else begin
      dl_v[0] <= pop;
      for (int n = 1; n < LAT; n++) dl_v[n] <= dl_v[n-1];
    end
  end

  always_ff @(posedge clk) begin
    dl_s[0] <= head.side;
    for (int n = 1; n < LAT; n++) dl_s[n] <= dl_s[n-1];
  end

  logic signed [61:0] px1, py1;
  logic signed [31:0] uz1, ux2, uy2, uz2;
  logic signed [47:0] prx3, pry3, prz3;
  logic signed [15:0] nx3, ny3, nz3, nx4, ny4, nz4, qx4, qy4, qz4;

  always_ff @(posedge clk) begin
    px1  <= c_st * c_se;
    py1  <= c_st * s_se;
    uz1  <= 32'(s_st);

    ux2  <= 32'(round_shift(64'(px1), 28));
    uy2  <= 32'(round_shift(64'(py1), 28));
    uz2  <= uz1;

    prx3 <= ux2 * $signed({1'b0, radius});
    pry3 <= uy2 * $signed({1'b0, radius});
    prz3 <= uz2 * $signed({1'b0, radius});
    nx3  <= sat16(round_shift(64'(ux2), 14), 64'sd16384);
    ny3  <= sat16(round_shift(64'(uy2), 14), 64'sd16384);
    nz3  <= sat16(round_shift(64'(uz2), 14), 64'sd16384);

    qx4  <= sat16(round_shift(64'(prx3), 28), 64'sd32767);
    qy4  <= sat16(round_shift(64'(pry3), 28), 64'sd32767);
    qz4  <= sat16(round_shift(64'(prz3), 28), 64'sd32767);
    nx4  <= nx3;
    ny4  <= ny3;
    nz4  <= nz3;
  end

  // serializer: vertex, then the pending triangles on the following cycles
  logic                        arrive;
  logic                        pend_a, pend_b;
  logic [usm_pkg::KIDX_W-1:0]  k1_h, k2_h;
  usm_pkg::side_t              side_end;

  assign arrive   = dl_v[LAT-1];
  assign side_end = dl_s[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      pend_a <= 1'b0;
      pend_b <= 1'b0;
    end else if (arrive) begin
      done   <= 1'b1;
      pend_a <= side_end.tri_a;
      pend_b <= side_end.tri_b;
    end else if (pend_a) begin
      done   <= 1'b1;
      pend_a <= 1'b0;
    end else if (pend_b) begin
      done   <= 1'b1;
      pend_b <= 1'b0;
    end else begin
      done   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (arrive) begin
      k1_h                <= side_end.k1;
      k2_h                <= side_end.k2;
      result.record_kind  <= usm_pkg::KIND_VERTEX;
      result.first_value  <= qx4;
      result.second_value <= qy4;
      result.third_value  <= qz4;
      result.normal_x     <= nx4;
      result.normal_y     <= ny4;
      result.normal_z     <= nz4;
      result.tex_s        <= side_end.ts;
      result.tex_t        <= side_end.tt;
      result.last_of_item <= !(side_end.tri_a || side_end.tri_b);
    end else begin
      result.record_kind  <= usm_pkg::KIND_TRIANGLE;
      result.normal_x     <= '0;
      result.normal_y     <= '0;
      result.normal_z     <= '0;
      result.tex_s        <= '0;
      result.tex_t        <= '0;
      if (pend_a) begin
        result.first_value  <= 16'(k1_h);
        result.second_value <= 16'(k2_h);
        result.third_value  <= 16'(k1_h) + 16'sd1;
        result.last_of_item <= !pend_b;
      end else begin
        result.first_value  <= 16'(k1_h) + 16'sd1;
        result.second_value <= 16'(k2_h);
        result.third_value  <= 16'(k2_h) + 16'sd1;
        result.last_of_item <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/uv_sphere_mesh_generator.sv -----
// Top level of the UV sphere mesh generator.
// Usage:
//   Input: drive item (stack_index, sector_index) and raise start; the
//   transaction is taken at a rising edge where start is high and busy low.
//   Output: each grid point yields a vertex record, then up to two triangle
//   records on the next cycles; done marks each record for one cycle and
//   last_of_item flags the final one. Grid points off the grid yield nothing.
//   Configuration: cfg_write with cfg_index 0 stack_count, 1 sector_count,
//   2 sphere_radius; other indexes are ignored. Write only while idle.
// Timing:
//   The vertex record of a transaction passes through the front stages,
//   the job queue and the back end pipeline before it appears.
//   Sustained throughput is set by the back end, which spaces out its job
//   issue so the record serializer never overflows.
//   The front end takes a new transaction every cycle until the job queue
//   plus the three front stages in flight reach the queue depth; busy then.
// Reset: synchronous; registers return to 18 stacks, 36 sectors, radius
//   16384, and the queue and pipelines are cleared.
// Receiver: cannot stall; done is a strobe and each record shows once.
module uv_sphere_mesh_generator #(
  parameter int MAX_STACKS  = usm_pkg::MAX_STACKS_DEF,
  parameter int MAX_SECTORS = usm_pkg::MAX_SECTORS_DEF,
  parameter int QUEUE_DEPTH = usm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  usm_pkg::item_t              item,
  output logic                        done,
  output usm_pkg::result_t            result,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [usm_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam int SUM_W = CNT_W + 2;

  usm_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stack_count   <= usm_pkg::RESET_STACKS;
      cfg.sector_count  <= usm_pkg::RESET_SECTORS;
      cfg.sphere_radius <= usm_pkg::RESET_RADIUS;
    end else if (cfg_write) begin
      case (usm_pkg::reg_index_t'(cfg_index))
        usm_pkg::REG_STACK_COUNT:   cfg.stack_count   <= cfg_data[usm_pkg::IDX_W-1:0];
        usm_pkg::REG_SECTOR_COUNT:  cfg.sector_count  <= cfg_data[usm_pkg::IDX_W-1:0];
        usm_pkg::REG_SPHERE_RADIUS: cfg.sphere_radius <= cfg_data[usm_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic              accept;
  logic              push;
  usm_pkg::job_t     push_job;
  logic [1:0]        inflight;
  logic              pop;
  usm_pkg::job_t     head;
  logic [CNT_W-1:0]  q_count;
  logic [SUM_W-1:0]  load;

  // queue slots are reserved for everything the front end still carries
  assign load   = SUM_W'(q_count) + SUM_W'(inflight);
  assign busy   = load >= SUM_W'(QUEUE_DEPTH);
  assign accept = start && !busy;

  usm_front #(
    .MAX_STACKS (MAX_STACKS),
    .MAX_SECTORS(MAX_SECTORS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (accept),
    .item    (item),
    .push    (push),
    .job     (push_job),
    .inflight(inflight)
  );

  usm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_job),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  usm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .radius   (cfg.sphere_radius),
    .not_empty(q_count != '0),
    .head     (head),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

endmodule

// ----- rtl/usm_checker.sv -----
// Port-level checks of the record stream, bound to the top level.
module usm_checker (
  input logic             clk,
  input logic             rst,
  input logic             done,
  input usm_pkg::result_t result
);

  // reset silences the result strobe
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("record strobed right after reset");

  // a triangle always follows an earlier record of the same transaction
  a_tri_follows: assert property (@(posedge clk) disable iff (rst)
    (done && result.record_kind) |-> ($past(done) && !$past(result.last_of_item)))
    else $error("triangle record without preceding record");

  // a vertex record opens a new transaction
  a_vertex_opens: assert property (@(posedge clk) disable iff (rst)
    (done && !result.record_kind) |-> (!$past(done) || $past(result.last_of_item)))
    else $error("vertex record inside an open transaction");

  // unit normal stays within Q1.14 one
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    (done && !result.record_kind) |->
      (result.normal_x >= -16'sd16384 && result.normal_x <= 16'sd16384 &&
       result.normal_y >= -16'sd16384 && result.normal_y <= 16'sd16384 &&
       result.normal_z >= -16'sd16384 && result.normal_z <= 16'sd16384))
    else $error("normal component out of range");

endmodule

bind uv_sphere_mesh_generator usm_checker u_usm_checker (
  .clk   (clk),
  .rst   (rst),
  .done  (done),
  .result(result)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the UV sphere mesh generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import usm_pkg::*;

  localparam int LATENCY = 48;

  logic clk, rst, start, busy, done, cfg_write;
  item_t item;
  result_t result;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  uv_sphere_mesh_generator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the register file
  logic [IDX_W-1:0] stacks_reg, sectors_reg;
  logic [RAD_W-1:0] radius_reg;

  result_t pending_records[$];
  int mismatches;

  // atan table in turn units, 2^32 per turn
  longint atan_turn[CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint rshift_round(longint v, int k);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // CORDIC sine/cosine of a 32-bit turn phase, Q2.28; shifts floor
  task automatic trig_turn(input logic [31:0] phase, output longint c, output longint s);
    logic [31:0] p;
    longint x, y, z, dx, dy;
    p = phase + 32'h2000_0000;
    z = longint'(p[29:0]) - 64'h2000_0000;
    x = 163008219;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn[k];
      end else begin
        x += dx; y -= dy; z += atan_turn[k];
      end
    end
    case (p[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic result_t tri_record(longint a, longint b, longint c);
    result_t r;
    r = '0;
    r.record_kind = KIND_TRIANGLE;
    r.first_value = 16'(sat(a, 32767));
    r.second_value = 16'(sat(b, 32767));
    r.third_value = 16'(sat(c, 32767));
    return r;
  endfunction

  // queue up the records one grid point should produce
  task automatic predict_mesh_records(input item_t it);
    longint st, se, i, j, rad, cst, sst, csc, ssc, k1, k2;
    longint u[3], nrm[3], pos[3];
    logic [31:0] ph_st, ph_se;
    result_t rec[$];
    result_t r;
    i = it.stack_index;
    j = it.sector_index;
    st = stacks_reg;
    se = sectors_reg;
    rad = radius_reg;
    if (st < MIN_STACKS) st = MIN_STACKS;
    if (st > MAX_STACKS_DEF) st = MAX_STACKS_DEF;
    if (se < MIN_SECTORS) se = MIN_SECTORS;
    if (se > MAX_SECTORS_DEF) se = MAX_SECTORS_DEF;
    if (i > st || j > se) return;
    ph_st = 32'(64'h4000_0000 - ((i << 31) / st));
    ph_se = 32'((j << 32) / se);
    trig_turn(ph_st, cst, sst);
    trig_turn(ph_se, csc, ssc);
    u[0] = rshift_round(cst * csc, 28);
    u[1] = rshift_round(cst * ssc, 28);
    u[2] = sst;
    for (int m = 0; m < 3; m++) begin
      nrm[m] = sat(rshift_round(u[m], 14), 16384);
      pos[m] = sat(rshift_round(u[m] * rad, 28), 32767);
    end
    r = '0;
    r.record_kind = KIND_VERTEX;
    r.first_value = 16'(pos[0]);
    r.second_value = 16'(pos[1]);
    r.third_value = 16'(pos[2]);
    r.normal_x = 16'(nrm[0]);
    r.normal_y = 16'(nrm[1]);
    r.normal_z = 16'(nrm[2]);
    r.tex_s = TEX_W'((i * 65536 + st / 2) / st);
    r.tex_t = TEX_W'((j * 65536 + se / 2) / se);
    rec = {rec, r};
    if (i < st && j < se) begin
      k1 = i * (se + 1) + j;
      k2 = k1 + se + 1;
      if (i != 0) rec = {rec, tri_record(k1, k2, k1 + 1)};
      if (i != st - 1) rec = {rec, tri_record(k1 + 1, k2, k2 + 1)};
    end
    rec[rec.size() - 1].last_of_item = 1'b1;
    pending_records = {pending_records, rec};
  endtask

  // result checker: done is a one-cycle strobe, sampled at the edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected record %p", result);
      end else begin
        result_t exp_rec;
        exp_rec = pending_records.pop_front();
        if (result !== exp_rec) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch\n  expected %p\n  actual   %p", exp_rec, result);
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_STACK_COUNT:   stacks_reg = val[IDX_W-1:0];
      REG_SECTOR_COUNT:  sectors_reg = val[IDX_W-1:0];
      REG_SPHERE_RADIUS: radius_reg = val[RAD_W-1:0];
      default: ;
    endcase
  endtask

  // unknown index: must be ignored, predictor unchanged
  task automatic write_bad_index(input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one transaction; start stays high across back-to-back items
  task automatic send_point(input item_t it, input bit keep_start);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_mesh_records(it);
    if (!keep_start) start <= 1'b0;
  endtask

  // random idle gap, never empty, so start is seen low
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 2);
    repeat (g) @(posedge clk);
  endtask

  // drain: wait for all records, then the pipeline latency
  task automatic drain();
    while (pending_records.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic random_points(input int count);
    item_t it;
    bit gap;
    for (int n = 0; n < count; n++) begin
      // mostly on-grid points, some off-grid and full-range noise
      if ($urandom_range(0, 7) == 0) begin
        it.stack_index = IDX_W'($urandom);
        it.sector_index = IDX_W'($urandom);
      end else begin
        it.stack_index = IDX_W'($urandom_range(0, 64));
        it.sector_index = IDX_W'($urandom_range(0, 64));
      end
      gap = ($urandom_range(0, 2) == 0) && (n % 40 < 30);
      send_point(it, !gap && n != count - 1);
      if (gap) idle_gap();
    end
  endtask

  // directed rows: grid points checked against the predictor
  typedef struct {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } point_row_t;

  point_row_t directed_rows[] = '{
    '{0, 0}, '{0, 35}, '{0, 36}, '{1, 0}, '{9, 9}, '{17, 35}, '{17, 0},
    '{18, 0}, '{18, 36}, '{19, 0}, '{0, 37}, '{127, 127}, '{64, 64},
    '{5, 18}, '{9, 27}, '{12, 1}
  };

  initial begin
    item_t it;
    mismatches = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_STACK_COUNT;
    cfg_data = '0;
    stacks_reg = RESET_STACKS;
    sectors_reg = RESET_SECTORS;
    radius_reg = RESET_RADIUS;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points at reset configuration
    foreach (directed_rows[n]) begin
      it.stack_index = directed_rows[n].i;
      it.sector_index = directed_rows[n].j;
      send_point(it, n != directed_rows.size() - 1);
    end
    drain();

    // smallest grid at full radius, poles, seams and points just off the grid
    write_reg(REG_STACK_COUNT, CFG_W'(2));
    write_reg(REG_SECTOR_COUNT, CFG_W'(3));
    write_reg(REG_SPHERE_RADIUS, 15'h7FFF);
    write_bad_index(15'h0001);
    for (int i = 0; i <= 3; i++)
      for (int j = 0; j <= 4; j++) begin
        it.stack_index = IDX_W'(i);
        it.sector_index = IDX_W'(j);
        send_point(it, !(i == 3 && j == 4));
      end
    drain();

    // register clamps and radius zero
    write_reg(REG_STACK_COUNT, CFG_W'(0));
    write_reg(REG_SECTOR_COUNT, CFG_W'(127));
    write_reg(REG_SPHERE_RADIUS, CFG_W'(0));
    random_points(20);
    drain();

    write_reg(REG_STACK_COUNT, CFG_W'(127));
    write_reg(REG_SECTOR_COUNT, CFG_W'(64));
    write_reg(REG_SPHERE_RADIUS, CFG_W'(1));
    random_points(50);
    drain();

    write_reg(REG_STACK_COUNT, CFG_W'(64));
    write_reg(REG_SECTOR_COUNT, CFG_W'(0));
    write_reg(REG_SPHERE_RADIUS, 15'h5555);
    random_points(40);
    drain();

    write_reg(REG_STACK_COUNT, CFG_W'($urandom_range(2, 64)));
    write_reg(REG_SECTOR_COUNT, CFG_W'($urandom_range(3, 64)));
    write_reg(REG_SPHERE_RADIUS, RAD_W'($urandom_range(1, 32767)));
    random_points(90);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
